[sv/direct_dft_accumulator_assert.svh]
// assertion macros for the direct dft accumulator
`ifndef DIRECT_DFT_ACCUMULATOR_ASSERT_SVH
`define DIRECT_DFT_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, checked at every rising clock edge out of reset
`define DFTACC_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("dftacc assertion failed");
// next-cycle implication
`define DFTACC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("dftacc assertion failed");
`else
`define DFTACC_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define DFTACC_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

[sv/dftacc_pkg.sv]
// shared types and constants of the direct dft accumulator
package dftacc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int BIN_W    = 8;
    localparam int ACC_W    = 40;
    localparam int TWID_W   = 16;
    localparam int PROD_W   = 32;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_RESP
    } state_t;

    typedef struct packed
    {
        logic rd_en;
        logic wr_en;
    } ram_ctl_t;

endpackage

[sv/dftacc_twiddle_rom.sv]
// constant q1.15 cosine and sine table with registered read
module dftacc_twiddle_rom
#(
    parameter int POINTS = 256
)
(
    input  logic                                       clk,
    input  logic [$clog2(POINTS)-1:0]                  addr,
    output logic signed [dftacc_pkg::TWID_W-1:0]       cos_val,
    output logic signed [dftacc_pkg::TWID_W-1:0]       sin_val
);

    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // six truncated taylor terms, q30
    function automatic logic [63:0] taylor_cos(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        longint      s;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        s  = longint'(t);
        t  = ((t * x2) >> 30) / 2;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 12;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 30;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 56;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 90;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 132;
        s  = s + longint'(t);
        if (s < 0)
        begin
            s = 0;
        end
        if (s > longint'(ONE_Q30))
        begin
            s = longint'(ONE_Q30);
        end
        return 64'(s);
    endfunction

    function automatic logic [63:0] taylor_sin(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        longint      s;
        x2 = (x * x) >> 30;
        t  = x;
        s  = longint'(t);
        t  = ((t * x2) >> 30) / 6;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 20;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 42;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 72;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 110;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 156;
        s  = s + longint'(t);
        if (s < 0)
        begin
            s = 0;
        end
        if (s > longint'(ONE_Q30))
        begin
            s = longint'(ONE_Q30);
        end
        return 64'(s);
    endfunction

    // round half away from zero, sign applied after rounding
    function automatic logic signed [15:0] to_q15(input logic [63:0] v, input logic neg);
        logic [63:0] r;
        logic [15:0] mag;
        r   = (v * 64'd32767 + (64'd1 << 29) + (64'd1 << 22)) >> 30;
        mag = r[15:0];
        return neg ? (16'sd0 - signed'(mag)) : signed'(mag);
    endfunction

    function automatic logic signed [15:0] twiddle(input int unsigned m, input logic want_sin);
        int unsigned         q;
        int unsigned         rem;
        int unsigned         a;
        logic                comp;
        logic [63:0]         x;
        logic [63:0]         c;
        logic [63:0]         s;
        logic [63:0]         t;
        logic signed [15:0]  cv;
        logic signed [15:0]  sv;
        q    = (4 * m) / POINTS;
        rem  = 4 * m - q * POINTS;
        comp = (2 * rem) > POINTS;
        a    = comp ? POINTS - rem : rem;
        x    = (64'(a) * HALF_PI_Q30) / POINTS;
        c    = taylor_cos(x);
        s    = taylor_sin(x);
        if (comp)
        begin
            t = c;
            c = s;
            s = t;
        end
        unique case (q[1:0])
            2'd0:
            begin
                cv = to_q15(c, 1'b0);
                sv = to_q15(s, 1'b0);
            end
            2'd1:
            begin
                cv = to_q15(s, 1'b1);
                sv = to_q15(c, 1'b0);
            end
            2'd2:
            begin
                cv = to_q15(c, 1'b1);
                sv = to_q15(s, 1'b1);
            end
            default:
            begin
                cv = to_q15(s, 1'b0);
                sv = to_q15(c, 1'b1);
            end
        endcase
        return want_sin ? sv : cv;
    endfunction

    logic signed [dftacc_pkg::TWID_W-1:0] cos_tab [POINTS];
    logic signed [dftacc_pkg::TWID_W-1:0] sin_tab [POINTS];
    logic signed [dftacc_pkg::TWID_W-1:0] cos_reg;
    logic signed [dftacc_pkg::TWID_W-1:0] sin_reg;

    for (genvar g = 0; g < POINTS; g++)
    begin : g_tab
        localparam logic signed [15:0] COS_V = twiddle(g, 1'b0);
        localparam logic signed [15:0] SIN_V = twiddle(g, 1'b1);
        assign cos_tab[g] = COS_V;
        assign sin_tab[g] = SIN_V;
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= cos_tab[addr];
        sin_reg <= sin_tab[addr];
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

[sv/dftacc_bin_ram.sv]
// real and imaginary bin accumulator memories, one write and one read port
module dftacc_bin_ram
#(
    parameter int POINTS = 256
)
(
    input  logic                                 clk,
    input  dftacc_pkg::ram_ctl_t                 ctl,
    input  logic [$clog2(POINTS)-1:0]            rd_addr,
    input  logic [$clog2(POINTS)-1:0]            wr_addr,
    input  logic signed [dftacc_pkg::ACC_W-1:0]  wr_real,
    input  logic signed [dftacc_pkg::ACC_W-1:0]  wr_imag,
    output logic signed [dftacc_pkg::ACC_W-1:0]  rd_real,
    output logic signed [dftacc_pkg::ACC_W-1:0]  rd_imag
);

    logic signed [dftacc_pkg::ACC_W-1:0] real_mem [POINTS];
    logic signed [dftacc_pkg::ACC_W-1:0] imag_mem [POINTS];
    logic signed [dftacc_pkg::ACC_W-1:0] rd_real_reg;
    logic signed [dftacc_pkg::ACC_W-1:0] rd_imag_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            real_mem[wr_addr] <= wr_real;
            imag_mem[wr_addr] <= wr_imag;
        end
        // read data holds while no read is issued
        if (ctl.rd_en)
        begin
            rd_real_reg <= real_mem[rd_addr];
            rd_imag_reg <= imag_mem[rd_addr];
        end
    end

    assign rd_real = rd_real_reg;
    assign rd_imag = rd_imag_reg;

endmodule

[sv/dftacc_mac.sv]
// complex multiply-accumulate of one sample against one twiddle pair
module dftacc_mac
(
    input  logic signed [dftacc_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [dftacc_pkg::TWID_W-1:0]   cos_val,
    input  logic signed [dftacc_pkg::TWID_W-1:0]   sin_val,
    input  logic signed [dftacc_pkg::ACC_W-1:0]    acc_real,
    input  logic signed [dftacc_pkg::ACC_W-1:0]    acc_imag,
    input  logic                                   first,
    output logic signed [dftacc_pkg::ACC_W-1:0]    sum_real,
    output logic signed [dftacc_pkg::ACC_W-1:0]    sum_imag
);

    logic signed [dftacc_pkg::PROD_W-1:0] prod_real;
    logic signed [dftacc_pkg::PROD_W-1:0] prod_imag;
    logic signed [dftacc_pkg::ACC_W-1:0]  ext_real;
    logic signed [dftacc_pkg::ACC_W-1:0]  ext_imag;

    assign prod_real = dftacc_pkg::PROD_W'(sample) * dftacc_pkg::PROD_W'(cos_val);
    // negated sine term, magnitude stays below 2^30
    assign prod_imag = 32'sd0 - (dftacc_pkg::PROD_W'(sample) * dftacc_pkg::PROD_W'(sin_val));
    assign ext_real  = dftacc_pkg::ACC_W'(prod_real);
    assign ext_imag  = dftacc_pkg::ACC_W'(prod_imag);

    // first sample of a frame overwrites the bin
    assign sum_real = first ? ext_real : acc_real + ext_real;
    assign sum_imag = first ? ext_imag : acc_imag + ext_imag;

endmodule

[sv/direct_dft_accumulator.sv]
// top level of the direct dft accumulator: sequencer, handshakes and result register
//
// Direct POINTS-point DFT that is updated one time-domain sample at a time. A sample
// item (req_type 0) is sample k of the current frame and updates every bin i with
// sample*cos and -sample*sin of twiddle (i*k) mod POINTS; the first sample of a frame
// overwrites the bins. A read item (req_type 1) returns the 40-bit Q30 sums of bin
// bin_index and frame_complete, which is set once POINTS samples were loaded; a bin at or
// above POINTS reads as zero sums. A sample sweeps all bins before the next acceptance:
// one read-modify-write per bin through the single read and write port of the bin
// memory, a drain state for the last write and the idle state that takes the next item.
// A read passes through the response state, held there while the result register is
// stalled. The bin memory is not cleared at reset, so a bin read before the first sample
// of the first frame returns undefined sums.
module direct_dft_accumulator
#(
    parameter int POINTS = 256
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  req_type,
    input  logic signed [dftacc_pkg::SAMPLE_W-1:0] sample,
    input  logic [dftacc_pkg::BIN_W-1:0]          bin_index,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [dftacc_pkg::BIN_W-1:0]          bin_number,
    output logic signed [dftacc_pkg::ACC_W-1:0]   real_part,
    output logic signed [dftacc_pkg::ACC_W-1:0]   imag_part,
    output logic                                  frame_complete
);

`include "direct_dft_accumulator_assert.svh"

    // address width of the bin memory and width of the sample count (0..POINTS)
    localparam int AW   = $clog2(POINTS);
    localparam int CW   = $clog2(POINTS + 1);
    localparam int CMPW = (CW > dftacc_pkg::BIN_W) ? CW : dftacc_pkg::BIN_W;

    localparam logic [AW-1:0]   LAST_BIN  = AW'(POINTS - 1);
    localparam logic [CW-1:0]   FULL_CNT  = CW'(POINTS);
    localparam logic [AW:0]     PHASE_MOD = (AW + 1)'(POINTS);
    localparam logic [CMPW-1:0] BIN_LIMIT = CMPW'(POINTS);

    // sequencer state
    dftacc_pkg::state_t state_reg;
    dftacc_pkg::state_t state_next;

    // frame bookkeeping
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [AW-1:0] k_reg;
    logic [AW-1:0] k_next;
    logic          first_reg;
    logic          first_next;

    // bin sweep: bin counter and twiddle phase (i*k mod POINTS kept as a running sum)
    logic [AW-1:0] bin_cnt_reg;
    logic [AW-1:0] bin_cnt_next;
    logic [AW-1:0] phase_reg;
    logic [AW-1:0] phase_next;
    logic [AW:0]   phase_sum;
    logic          bin_last;

    // write-back stage, in the cycle after the memory read
    logic          v1_reg;
    logic          v1_next;
    logic [AW-1:0] wr_addr_reg;
    logic [AW-1:0] wr_addr_next;

    // latched item payload
    logic signed [dftacc_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [dftacc_pkg::SAMPLE_W-1:0] sample_next;
    logic [dftacc_pkg::BIN_W-1:0]           bin_reg;
    logic [dftacc_pkg::BIN_W-1:0]           bin_next;
    logic                                   range_reg;
    logic                                   range_next;

    // result register
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic [dftacc_pkg::BIN_W-1:0]         out_bin_reg;
    logic [dftacc_pkg::BIN_W-1:0]         out_bin_next;
    logic signed [dftacc_pkg::ACC_W-1:0]  out_real_reg;
    logic signed [dftacc_pkg::ACC_W-1:0]  out_real_next;
    logic signed [dftacc_pkg::ACC_W-1:0]  out_imag_reg;
    logic signed [dftacc_pkg::ACC_W-1:0]  out_imag_next;
    logic                                 out_done_reg;
    logic                                 out_done_next;

    // handshake and control
    logic            accept_in;
    logic            accept_sample;
    logic            accept_read;
    logic            out_free;
    logic            out_load;
    logic [CMPW-1:0] bin_ext;
    logic            bin_in_range;
    logic [AW-1:0]   k_sel;
    logic [AW-1:0]   rd_addr;

    dftacc_pkg::ram_ctl_t ram_ctl;

    // datapath
    logic signed [dftacc_pkg::TWID_W-1:0] cos_val;
    logic signed [dftacc_pkg::TWID_W-1:0] sin_val;
    logic signed [dftacc_pkg::ACC_W-1:0]  rd_real;
    logic signed [dftacc_pkg::ACC_W-1:0]  rd_imag;
    logic signed [dftacc_pkg::ACC_W-1:0]  sum_real;
    logic signed [dftacc_pkg::ACC_W-1:0]  sum_imag;

    assign accept_in     = in_valid && !in_stall;
    assign accept_sample = accept_in && !req_type;
    assign accept_read   = accept_in && req_type;
    assign out_free      = !out_valid_reg || !out_stall;

    assign bin_ext      = CMPW'(bin_index);
    assign bin_in_range = bin_ext < BIN_LIMIT;

    // a full frame wraps: the next sample is k = 0 again
    assign k_sel    = (cnt_reg == FULL_CNT) ? '0 : cnt_reg[AW-1:0];
    assign bin_last = bin_cnt_reg == LAST_BIN;

    assign phase_sum = {1'b0, phase_reg} + {1'b0, k_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dftacc_pkg::ST_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = req_type ? dftacc_pkg::ST_RESP : dftacc_pkg::ST_RUN;
                end
            end
            dftacc_pkg::ST_RUN:
            begin
                if (bin_last)
                begin
                    state_next = dftacc_pkg::ST_DRAIN;
                end
            end
            dftacc_pkg::ST_DRAIN:
            begin
                state_next = dftacc_pkg::ST_IDLE;
            end
            dftacc_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = dftacc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dftacc_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall      = 1'b1;
        ram_ctl.rd_en = 1'b0;
        // write-back of the bin read in the previous cycle
        ram_ctl.wr_en = v1_reg;
        rd_addr       = bin_cnt_reg;
        out_load      = 1'b0;
        unique case (state_reg)
            dftacc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                // a bin read goes to memory in the accepting cycle
                ram_ctl.rd_en = accept_read && bin_in_range;
                rd_addr       = bin_ext[AW-1:0];
            end
            dftacc_pkg::ST_RUN:
            begin
                ram_ctl.rd_en = 1'b1;
            end
            dftacc_pkg::ST_DRAIN:
            begin
                ram_ctl.rd_en = 1'b0;
            end
            dftacc_pkg::ST_RESP:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // register next values
    always_comb
    begin
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        first_next   = first_reg;
        bin_cnt_next = bin_cnt_reg;
        phase_next   = phase_reg;
        sample_next  = sample_reg;
        bin_next     = bin_reg;
        range_next   = range_reg;
        v1_next      = state_reg == dftacc_pkg::ST_RUN;
        wr_addr_next = bin_cnt_reg;

        if (accept_sample)
        begin
            k_next       = k_sel;
            first_next   = k_sel == '0;
            cnt_next     = CW'(k_sel) + CW'(1);
            bin_cnt_next = '0;
            phase_next   = '0;
            sample_next  = sample;
        end
        if (accept_read)
        begin
            bin_next   = bin_index;
            range_next = bin_in_range;
        end
        if (state_reg == dftacc_pkg::ST_RUN)
        begin
            bin_cnt_next = bin_cnt_reg + AW'(1);
            if (phase_sum >= PHASE_MOD)
            begin
                phase_next = AW'(phase_sum - PHASE_MOD);
            end
            else
            begin
                phase_next = phase_sum[AW-1:0];
            end
        end
    end

    // result register next values
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_bin_next   = out_bin_reg;
        out_real_next  = out_real_reg;
        out_imag_next  = out_imag_reg;
        out_done_next  = out_done_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_bin_next   = bin_reg;
            out_real_next  = range_reg ? rd_real : '0;
            out_imag_next  = range_reg ? rd_imag : '0;
            out_done_next  = cnt_reg == FULL_CNT;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dftacc_pkg::ST_IDLE;
            cnt_reg       <= '0;
            k_reg         <= '0;
            first_reg     <= 1'b0;
            bin_cnt_reg   <= '0;
            phase_reg     <= '0;
            v1_reg        <= 1'b0;
            range_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            first_reg     <= first_next;
            bin_cnt_reg   <= bin_cnt_next;
            phase_reg     <= phase_next;
            v1_reg        <= v1_next;
            range_reg     <= range_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        wr_addr_reg  <= wr_addr_next;
        sample_reg   <= sample_next;
        bin_reg      <= bin_next;
        out_bin_reg  <= out_bin_next;
        out_real_reg <= out_real_next;
        out_imag_reg <= out_imag_next;
        out_done_reg <= out_done_next;
    end

    dftacc_twiddle_rom
    #(
        .POINTS (POINTS)
    )
    u_rom
    (
        .clk     (clk),
        .addr    (phase_reg),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    dftacc_bin_ram
    #(
        .POINTS (POINTS)
    )
    u_ram
    (
        .clk     (clk),
        .ctl     (ram_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr_reg),
        .wr_real (sum_real),
        .wr_imag (sum_imag),
        .rd_real (rd_real),
        .rd_imag (rd_imag)
    );

    dftacc_mac u_mac
    (
        .sample   (sample_reg),
        .cos_val  (cos_val),
        .sin_val  (sin_val),
        .acc_real (rd_real),
        .acc_imag (rd_imag),
        .first    (first_reg),
        .sum_real (sum_real),
        .sum_imag (sum_imag)
    );

    assign out_valid      = out_valid_reg;
    assign bin_number     = out_bin_reg;
    assign real_part      = out_real_reg;
    assign imag_part      = out_imag_reg;
    assign frame_complete = out_done_reg;

    // memory writes only happen while a sample sweeps the bins
    `DFTACC_ASSERT_IMPLIES(a_wr_in_sweep, clk, rst_n, ram_ctl.wr_en, (state_reg == dftacc_pkg::ST_RUN) || (state_reg == dftacc_pkg::ST_DRAIN))
    // the last bin issued is written back in the drain cycle
    `DFTACC_ASSERT_NEXT(a_last_drain, clk, rst_n, (state_reg == dftacc_pkg::ST_RUN) && bin_last, (state_reg == dftacc_pkg::ST_DRAIN) && ram_ctl.wr_en && (wr_addr_reg == LAST_BIN))
    // a sweep starts at bin zero with twiddle phase zero
    `DFTACC_ASSERT_NEXT(a_sweep_start, clk, rst_n, accept_sample, (state_reg == dftacc_pkg::ST_RUN) && (bin_cnt_reg == '0) && (phase_reg == '0))
    // a new result only comes out of the response state
    `DFTACC_ASSERT_IMPLIES(a_out_from_resp, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == dftacc_pkg::ST_RESP)

endmodule

[tb/sv/tb.sv]
// self-checking testbench for the direct dft accumulator: bin prediction, stimulus and result check
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POINTS = 256;

    // request kinds carried by req_type
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // twiddle generation in q30 fixed point
    localparam longint          Q30_ONE     = 64'sd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TIE_BIAS    = 64'd1 << 22;

    // watchdog: the slowest legal run is well under 5 ms
    localparam longint RUN_LIMIT_NS = 64'd20_000_000;

    typedef struct
    {
        logic [dftacc_pkg::BIN_W-1:0] bin;
        logic [dftacc_pkg::ACC_W-1:0] re;
        logic [dftacc_pkg::ACC_W-1:0] im;
        logic                         done;
    } bin_result_t;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   in_valid;
    logic                                   in_stall;
    logic                                   req_type;
    logic signed [dftacc_pkg::SAMPLE_W-1:0] sample;
    logic [dftacc_pkg::BIN_W-1:0]           bin_index;
    logic                                   out_valid;
    logic                                   out_stall;
    logic [dftacc_pkg::BIN_W-1:0]           bin_number;
    logic signed [dftacc_pkg::ACC_W-1:0]    real_part;
    logic signed [dftacc_pkg::ACC_W-1:0]    imag_part;
    logic                                   frame_complete;

    // predicted dft state: twiddle tables, bin sums and the frame position
    int                           cos_tab [POINTS];
    int                           sin_tab [POINTS];
    logic [dftacc_pkg::ACC_W-1:0] re_acc  [POINTS];
    logic [dftacc_pkg::ACC_W-1:0] im_acc  [POINTS];
    int unsigned                  frame_count;

    // bin reads accepted by the block whose results have not come back yet
    bin_result_t bin_reads_q[$];

    int unsigned gap_max;
    int unsigned stall_max;
    int unsigned fail_count;
    int unsigned results_taken;
    int unsigned stall_seen;
    int unsigned stall_left;

    direct_dft_accumulator
    #(
        .POINTS (POINTS)
    )
    u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .sample         (sample),
        .bin_index      (bin_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .bin_number     (bin_number),
        .real_part      (real_part),
        .imag_part      (imag_part),
        .frame_complete (frame_complete)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // twiddle table, built the same integer way as the block's rom
    // ------------------------------------------------------------------

    // seven-term taylor series for an angle in [0, pi/4], each term after the first truncated
    function automatic longint series_q30(longint unsigned x, bit sine);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned div;
        longint          acc;
        longint unsigned n;
        x2 = (x * x) >> 30;
        term = sine ? x : longint'(Q30_ONE);
        acc = longint'(term);
        for (n = 1; n <= 6; n++)
        begin
            div = sine ? (2 * n) * (2 * n + 1) : (2 * n - 1) * (2 * n);
            term = ((term * x2) >> 30) / div;
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > Q30_ONE)
            acc = Q30_ONE;
        return acc;
    endfunction

    // q30 magnitude to q1.15, ties away from zero, sign applied last
    function automatic int q15_round(longint mag, bit neg);
        longint unsigned r;
        r = (longint'(mag) * 32767 + (Q30_ONE >> 1) + TIE_BIAS) >> 30;
        return neg ? -int'(r) : int'(r);
    endfunction

    task automatic twiddle_build();
        int unsigned     m;
        int unsigned     quad;
        int unsigned     rem;
        int unsigned     ang;
        bit              fold;
        longint unsigned x;
        longint          c;
        longint          s;
        longint          t;
        for (m = 0; m < POINTS; m++)
        begin
            // fold the angle by quadrant, then by octant
            quad = (4 * m) / POINTS;
            rem  = 4 * m - quad * POINTS;
            fold = (2 * rem) > POINTS;
            ang  = fold ? POINTS - rem : rem;
            x = (longint'(ang) * HALF_PI_Q30) / POINTS;
            c = series_q30(x, 1'b0);
            s = series_q30(x, 1'b1);
            if (fold)
            begin
                t = c;
                c = s;
                s = t;
            end
            case (quad % 4)
                0:
                begin
                    cos_tab[m] = q15_round(c, 1'b0);
                    sin_tab[m] = q15_round(s, 1'b0);
                end
                1:
                begin
                    cos_tab[m] = q15_round(s, 1'b1);
                    sin_tab[m] = q15_round(c, 1'b0);
                end
                2:
                begin
                    cos_tab[m] = q15_round(c, 1'b1);
                    sin_tab[m] = q15_round(s, 1'b1);
                end
                default:
                begin
                    cos_tab[m] = q15_round(s, 1'b0);
                    sin_tab[m] = q15_round(c, 1'b1);
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // bin predictor
    // ------------------------------------------------------------------

    // one time-domain sample: every bin gets sample times its twiddle,
    // the first sample of a frame overwrites instead of adding
    task automatic dft_load_sample(logic signed [dftacc_pkg::SAMPLE_W-1:0] x);
        int unsigned k;
        int unsigned i;
        int unsigned idx;
        longint      prod_re;
        longint      prod_im;
        // a full frame wraps: this sample starts the next one
        if (frame_count >= POINTS)
            frame_count = 0;
        k = frame_count;
        for (i = 0; i < POINTS; i++)
        begin
            idx = (i * k) % POINTS;
            prod_re = longint'(x) * cos_tab[idx];
            prod_im = -(longint'(x) * sin_tab[idx]);
            if (k == 0)
            begin
                re_acc[i] = prod_re[dftacc_pkg::ACC_W-1:0];
                im_acc[i] = prod_im[dftacc_pkg::ACC_W-1:0];
            end
            else
            begin
                // sums wrap modulo 2^40
                re_acc[i] = re_acc[i] + prod_re[dftacc_pkg::ACC_W-1:0];
                im_acc[i] = im_acc[i] + prod_im[dftacc_pkg::ACC_W-1:0];
            end
        end
        frame_count = k + 1;
    endtask

    // one bin read: the result the block owes for it
    function automatic bin_result_t dft_read_bin(logic [dftacc_pkg::BIN_W-1:0] b);
        bin_result_t r;
        r.bin  = b;
        r.re   = '0;
        r.im   = '0;
        // bins at or above the transform size read as zero sums
        if (b < POINTS)
        begin
            r.re = re_acc[b];
            r.im = im_acc[b];
        end
        r.done = (frame_count == POINTS);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // waits a random gap, offers one item and holds it until taken;
    // valid stays high after acceptance so a zero gap needs no re-raise
    task automatic send_item(logic req, logic signed [dftacc_pkg::SAMPLE_W-1:0] smp,
                             logic [dftacc_pkg::BIN_W-1:0] bin);
        int unsigned gap;
        gap = $urandom_range(0, gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        sample    <= smp;
        bin_index <= bin;
        do
            @(posedge clk);
        while (in_stall);
        // accepted at this edge: update the predicted state
        if (req == REQ_SAMPLE)
            dft_load_sample(smp);
        else
            bin_reads_q.insert(bin_reads_q.size(), dft_read_bin(bin));
    endtask

    // drop valid, then let every owed result come back and any sample in flight finish
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (bin_reads_q.size() != 0)
            @(posedge clk);
        repeat (POINTS + 8) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------

    // receiver stall: a fresh random hold-off after each taken result
    always @(negedge clk)
    begin
        if (results_taken != stall_seen)
        begin
            stall_seen = results_taken;
            stall_left = $urandom_range(0, stall_max);
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // every taken result is checked against the oldest owed read
    always @(posedge clk)
    begin : check_result
        bin_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_taken = results_taken + 1;
            if (bin_reads_q.size() == 0)
            begin
                $error("result with no read pending: bin_number %0d", bin_number);
                fail_count = fail_count + 1;
            end
            else
            begin
                want = bin_reads_q.pop_front();
                if (bin_number !== want.bin)
                begin
                    $error("bin_number: expected %0d, got %0d", want.bin, bin_number);
                    fail_count = fail_count + 1;
                end
                if (real_part !== want.re)
                begin
                    $error("real_part: expected %0d, got %0d",
                           $signed(want.re), real_part);
                    fail_count = fail_count + 1;
                end
                if (imag_part !== want.im)
                begin
                    $error("imag_part: expected %0d, got %0d",
                           $signed(want.im), imag_part);
                    fail_count = fail_count + 1;
                end
                if (frame_complete !== want.done)
                begin
                    $error("frame_complete: expected %0d, got %0d",
                           want.done, frame_complete);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // sample extremes and reads of edge bins early in a frame; the very first
    // item is a sample so that no bin is read before it was written
    task automatic test_directed();
        gap_max   = 19;
        stall_max = 19;
        send_item(REQ_SAMPLE, 16'sh7fff, 8'd0);
        send_item(REQ_READ,   16'sh0000, 8'd0);
        send_item(REQ_READ,   16'sh0000, 8'd255);
        send_item(REQ_SAMPLE, 16'sh8000, 8'd0);
        send_item(REQ_READ,   16'sh0000, 8'd1);
        send_item(REQ_READ,   16'sh0000, 8'd128);
        send_item(REQ_SAMPLE, 16'sh0000, 8'd0);
        send_item(REQ_SAMPLE, 16'shffff, 8'd0);
        send_item(REQ_SAMPLE, 16'sh0001, 8'd0);
        send_item(REQ_SAMPLE, 16'sh5555, 8'd0);
        send_item(REQ_SAMPLE, 16'shaaaa, 8'd0);
        // partial sums mid frame
        send_item(REQ_READ,   16'sh0000, 8'd64);
        send_item(REQ_READ,   16'sh0000, 8'd192);
        send_item(REQ_READ,   16'sh0000, 8'd127);
        send_item(REQ_READ,   16'sh0000, 8'hff);
        // back-to-back reads with no stall
        gap_max   = 0;
        stall_max = 0;
        send_item(REQ_READ,   16'sh0000, 8'd85);
        send_item(REQ_READ,   16'sh0000, 8'd170);
        send_item(REQ_READ,   16'sh0000, 8'd2);
        wait_idle();
    endtask

    // whole frames with scattered reads, then reads of the finished frame;
    // the next frame's first sample checks the wrap and overwrite
    task automatic test_full_frames();
        int unsigned                            f;
        int unsigned                            n;
        logic signed [dftacc_pkg::SAMPLE_W-1:0] x;
        for (f = 0; f < 3; f++)
        begin
            // middle frame runs with no idling on either side
            gap_max   = (f == 1) ? 0 : 19;
            stall_max = (f == 1) ? 0 : 19;
            do
            begin
                case (f)
                    0: x = dftacc_pkg::SAMPLE_W'($urandom_range(0, 16'hffff));
                    // largest magnitude everywhere: bin 0 nears the 40-bit range
                    1: x = 16'sh8000;
                    default: x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                endcase
                send_item(REQ_SAMPLE, x,
                          dftacc_pkg::BIN_W'($urandom_range(0, POINTS - 1)));
                if ($urandom_range(0, 3) == 0)
                    send_item(REQ_READ,
                              dftacc_pkg::SAMPLE_W'($urandom_range(0, 16'hffff)),
                              dftacc_pkg::BIN_W'($urandom_range(0, POINTS - 1)));
            end
            while (frame_count != POINTS);
            // frame done: complete flag must show on these
            send_item(REQ_READ, dftacc_pkg::SAMPLE_W'($urandom_range(0, 16'hffff)), 8'd0);
            send_item(REQ_READ, dftacc_pkg::SAMPLE_W'($urandom_range(0, 16'hffff)),
                      dftacc_pkg::BIN_W'(POINTS / 2));
            send_item(REQ_READ, dftacc_pkg::SAMPLE_W'($urandom_range(0, 16'hffff)),
                      dftacc_pkg::BIN_W'(POINTS - 1));
            for (n = 0; n < 12; n++)
                send_item(REQ_READ, dftacc_pkg::SAMPLE_W'($urandom_range(0, 16'hffff)),
                          dftacc_pkg::BIN_W'($urandom_range(0, POINTS - 1)));
        end
        wait_idle();
    endtask

    // loose mix of samples and reads with random fields, crossing frame ends
    task automatic test_random_mix();
        int unsigned n;
        gap_max   = 19;
        stall_max = 19;
        for (n = 0; n < 380; n++)
        begin
            if ($urandom_range(0, 1) == 0)
                send_item(REQ_SAMPLE, dftacc_pkg::SAMPLE_W'($urandom_range(0, 16'hffff)),
                          dftacc_pkg::BIN_W'($urandom_range(0, POINTS - 1)));
            else
                send_item(REQ_READ, dftacc_pkg::SAMPLE_W'($urandom_range(0, 16'hffff)),
                          dftacc_pkg::BIN_W'($urandom_range(0, POINTS - 1)));
        end
    endtask

    // ------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        req_type      = REQ_SAMPLE;
        sample        = '0;
        bin_index     = '0;
        out_stall     = 1'b0;
        gap_max       = 0;
        stall_max     = 0;
        fail_count    = 0;
        results_taken = 0;
        stall_seen    = 0;
        stall_left    = 0;
        frame_count   = 0;
        twiddle_build();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_full_frames();
        test_random_mix();

        // drain everything still owed, then let any sample in flight finish
        wait_idle();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog against a hung handshake or a result that never comes
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
